### hw/rtl/page_map_allocator_macros.svh
// Assertion helpers for the page map allocator.
// Each macro expects clk_i and rst_ni in scope.
`ifndef PAGE_MAP_ALLOCATOR_MACROS_SVH
`define PAGE_MAP_ALLOCATOR_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define PMA_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define PMA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/pma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pma_pkg;

  localparam int unsigned PMA_PAGES_DEFAULT = 1024;
  localparam int unsigned PMA_PAGE_COUNT_RESET = 1024;

  // bitmap word: one bit per page
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W = $clog2(WORD_BITS);

  localparam int unsigned CMD_W = 2;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_OOM   = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

endpackage

`default_nettype wire

### hw/rtl/page_map_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Ports                                        Transaction
// ----------  -------------------------------------------  ---------------------------------
// command     start_i, busy_o, cmd_i, page_index_i          start_i && !busy_o at clk edge
// config      page_count_we_i, page_count_i                 page_count_we_i at clk edge
// result      done_o, alloc_index_o, status_o,              done_o high for one cycle
//             used_pages_o, free_pages_o
//
// Query and rejected commands answer straight from idle; free and mark do a
// read-modify-write of one bitmap word (ST_RMW); allocate scans the words from
// word 0 and stops at the first word with a free page, or after the last word when full.
// The bitmap RAM, one read and one write port, yields one 32-bit word a cycle.
// Reset and every page_count write clear the map, busy_o high. No receiver stall.

module page_map_allocator
  import pma_pkg::*;
#(
  parameter int unsigned PAGES = PMA_PAGES_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command
  input  wire logic              start_i,
  output      logic              busy_o,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [IDX_W-1:0]  page_index_i,
  // configuration
  input  wire logic              page_count_we_i,
  input  wire logic [CNT_W-1:0]  page_count_i,
  // result
  output      logic              done_o,
  output      logic [IDX_W-1:0]  alloc_index_o,
  output      logic [STAT_W-1:0] status_o,
  output      logic [CNT_W-1:0]  used_pages_o,
  output      logic [CNT_W-1:0]  free_pages_o
);

  localparam int unsigned WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RMW
  } state_e;

  // bitmap RAM, no reset: cleared by the sweep
  logic [WORD_BITS-1:0] map_mem_q [WORDS];
  logic [WORD_BITS-1:0] rd_data_q;

  state_e               state_q;
  logic [AW-1:0]        row_q;      // sweep / scan issue address
  logic                 issue_q;    // scan still issuing reads
  logic                 dv_q;       // rd_data_q holds word drow_q
  logic [AW-1:0]        drow_q;     // word under evaluation / RMW word
  logic [BIT_W-1:0]     bitpos_q;
  logic                 is_free_q;
  logic [CNT_W-1:0]     used_q;
  logic [CNT_W-1:0]     page_cnt_q;
  logic                 done_q;
  logic [IDX_W-1:0]     alloc_idx_q;
  logic [STAT_W-1:0]    status_q;

  // effective page count, limits of the scan
  logic [CNT_W-1:0]     eff_cnt;
  logic [CNT_W-1:0]     eff_m1;
  logic [AW-1:0]        last_row;
  logic [BIT_W-1:0]     last_bit;

  assign eff_cnt  = (32'(page_cnt_q) > 32'(PAGES)) ? CNT_W'(PAGES) : page_cnt_q;
  assign eff_m1   = eff_cnt - CNT_W'(1);
  assign last_row = AW'(eff_m1 >> BIT_W);
  assign last_bit = eff_m1[BIT_W-1:0];

  // command decode
  logic                 accept;
  logic                 in_range;
  logic [AW-1:0]        idx_row;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign in_range = ({1'b0, page_index_i} < eff_cnt);
  assign idx_row  = AW'(page_index_i >> BIT_W);

  // first-zero search over the word just read; pages past the count look used
  logic [WORD_BITS-1:0] masked;
  logic [BIT_W-1:0]     fz;
  logic                 hit;
  logic [AW+BIT_W-1:0]  gidx;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      masked[j] = rd_data_q[j] || ((drow_q == last_row) && (BIT_W'(j) > last_bit));
    end
  end

  always_comb begin
    fz = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!masked[j]) begin
        fz = BIT_W'(j);
      end
    end
  end

  assign hit  = ~&masked;
  assign gidx = {drow_q, fz};

  // RMW target bit
  logic cur_bit;
  assign cur_bit = rd_data_q[bitpos_q];

  // RAM port control
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = row_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept && (cmd_i inside {CMD_FREE, CMD_MARK}) && in_range) begin
          mem_re    = 1'b1;
          mem_raddr = idx_row;
        end
      end
      ST_SCAN: begin
        mem_re = issue_q;
        if (dv_q && hit) begin
          mem_we    = 1'b1;
          mem_waddr = drow_q;
          mem_wdata = rd_data_q | (WORD_BITS'(1) << fz);
        end
      end
      ST_RMW: begin
        mem_waddr = drow_q;
        if (is_free_q && cur_bit) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data_q & ~(WORD_BITS'(1) << bitpos_q);
        end else if (!is_free_q && !cur_bit) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data_q | (WORD_BITS'(1) << bitpos_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= map_mem_q[mem_raddr];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_q       <= '0;
      issue_q     <= 1'b0;
      dv_q        <= 1'b0;
      drow_q      <= '0;
      bitpos_q    <= '0;
      is_free_q   <= 1'b0;
      used_q      <= '0;
      page_cnt_q  <= CNT_W'(PMA_PAGE_COUNT_RESET);
      done_q      <= 1'b0;
      alloc_idx_q <= '0;
      status_q    <= STAT_OK;
    end else begin
      done_q <= 1'b0;
      if (page_count_we_i) begin
        // new count: wipe the map as at boot
        page_cnt_q <= page_count_i;
        used_q     <= '0;
        state_q    <= ST_CLEAR;
        row_q      <= '0;
        issue_q    <= 1'b0;
        dv_q       <= 1'b0;
      end else begin
        case (state_q)
          ST_CLEAR: begin
            row_q <= row_q + AW'(1);
            if (row_q == AW'(WORDS - 1)) begin
              state_q <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (start_i) begin
              case (cmd_e'(cmd_i))
                CMD_ALLOC: begin
                  if (eff_cnt == '0) begin
                    done_q      <= 1'b1;
                    status_q    <= STAT_OOM;
                    alloc_idx_q <= '0;
                  end else begin
                    row_q   <= '0;
                    issue_q <= 1'b1;
                    dv_q    <= 1'b0;
                    state_q <= ST_SCAN;
                  end
                end
                CMD_FREE, CMD_MARK: begin
                  if (!in_range) begin
                    done_q      <= 1'b1;
                    status_q    <= STAT_RANGE;
                    alloc_idx_q <= '0;
                  end else begin
                    drow_q    <= idx_row;
                    bitpos_q  <= page_index_i[BIT_W-1:0];
                    is_free_q <= (cmd_e'(cmd_i) == CMD_FREE);
                    state_q   <= ST_RMW;
                  end
                end
                default: begin
                  done_q      <= 1'b1;
                  status_q    <= STAT_OK;
                  alloc_idx_q <= '0;
                end
              endcase
            end
          end
          ST_SCAN: begin
            // issue next word while checking the previous one
            if (issue_q) begin
              row_q   <= row_q + AW'(1);
              issue_q <= (row_q != last_row);
              drow_q  <= row_q;
              dv_q    <= 1'b1;
            end else begin
              dv_q <= 1'b0;
            end
            if (dv_q) begin
              if (hit) begin
                used_q      <= used_q + CNT_W'(1);
                done_q      <= 1'b1;
                status_q    <= STAT_OK;
                alloc_idx_q <= IDX_W'(gidx);
                issue_q     <= 1'b0;
                dv_q        <= 1'b0;
                state_q     <= ST_IDLE;
              end else if (!issue_q) begin
                // last word checked, nothing free
                done_q      <= 1'b1;
                status_q    <= STAT_OOM;
                alloc_idx_q <= '0;
                state_q     <= ST_IDLE;
              end
            end
          end
          ST_RMW: begin
            if (is_free_q && cur_bit) begin
              used_q <= used_q - CNT_W'(1);
            end else if (!is_free_q && !cur_bit) begin
              used_q <= used_q + CNT_W'(1);
            end
            done_q      <= 1'b1;
            status_q    <= STAT_OK;
            alloc_idx_q <= '0;
            state_q     <= ST_IDLE;
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

  assign done_o        = done_q;
  assign alloc_index_o = alloc_idx_q;
  assign status_o      = status_q;
  assign used_pages_o  = used_q;
  assign free_pages_o  = eff_cnt - used_q;

  // grant is zero or inside the managed pages
  logic grant_ok;
  assign grant_ok = (alloc_index_o == '0) || ({1'b0, alloc_index_o} < eff_cnt);

`include "page_map_allocator_macros.svh"

  `PMA_ASSERT(a_used_le_count, used_q <= eff_cnt, "used count above page count")
  `PMA_ASSERT_NEXT(a_accept_prog, accept && !page_count_we_i, busy_o || done_o, "transaction lost")
  `PMA_ASSERT_IMPL(a_scan_bnd, state_q == ST_SCAN && issue_q, row_q <= last_row, "scan overrun")
  `PMA_ASSERT_IMPL(a_grant_in_map, done_o, grant_ok, "grant beyond page count")

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

// Block-level bench for page_map_allocator (first-fit bitmap page allocator).
//
// Method:
//   - Commands go in on the start/busy handshake. A transaction is taken at a
//     rising edge where start_i is high and busy_o is low.
//   - At each accepted transaction a behavioral copy of the page map computes
//     the result it should produce: granted index, status, used and free
//     counts. That result joins a FIFO of pending results.
//   - The result side has no back-pressure. Every done_o pulse is popped
//     against the oldest pending result and compared field by field.
//   - page_count is written only with the FIFO empty and start_i low. Each
//     write clears the map in the DUT and in the bench copy.
//
// Sequence:
//   directed ops at the full map, a 3-page map (out of memory, out of range),
//   the zero, oversize and single-page corners, then random phases with
//   varied map sizes and sender idle rates.

module tb_top;
  import pma_pkg::*;

  localparam int unsigned MAP_PAGES = PMA_PAGES_DEFAULT;

  // Expected result of one command.
  typedef struct {
    logic [IDX_W-1:0] alloc_index;
    status_e          status;
    logic [CNT_W-1:0] used_pages;
    logic [CNT_W-1:0] free_pages;
  } page_result_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              start_i         = 1'b0;
  logic              busy_o;
  logic [CMD_W-1:0]  cmd_i           = '0;
  logic [IDX_W-1:0]  page_index_i    = '0;
  logic              page_count_we_i = 1'b0;
  logic [CNT_W-1:0]  page_count_i    = '0;
  logic              done_o;
  logic [IDX_W-1:0]  alloc_index_o;
  logic [STAT_W-1:0] status_o;
  logic [CNT_W-1:0]  used_pages_o;
  logic [CNT_W-1:0]  free_pages_o;

  // Bench copy of the allocator state.
  bit [MAP_PAGES-1:0] page_mark;
  int unsigned        used_total;
  logic [CNT_W-1:0]   pages_cfg;

  page_result_t pending_results[$];

  int unsigned fail_count;
  int unsigned cmds_sent;
  int unsigned results_seen;
  int unsigned grants_seen;
  int unsigned oom_seen;
  int unsigned range_seen;

  always #4 clk_i = ~clk_i;

  page_map_allocator #(
    .PAGES(MAP_PAGES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .page_index_i   (page_index_i),
    .page_count_we_i(page_count_we_i),
    .page_count_i   (page_count_i),
    .done_o         (done_o),
    .alloc_index_o  (alloc_index_o),
    .status_o       (status_o),
    .used_pages_o   (used_pages_o),
    .free_pages_o   (free_pages_o)
  );

  // Applies one command to the bench copy of the map.
  // The page count saturates at the map size, so 0 manages no page at all.
  function automatic page_result_t predict_page_op(cmd_e op, logic [IDX_W-1:0] idx);
    page_result_t r;
    int unsigned  span;
    int unsigned  k;
    bit           found;
    span          = (pages_cfg > MAP_PAGES) ? MAP_PAGES : pages_cfg;
    r.alloc_index = '0;
    r.status      = STAT_OK;
    found         = 1'b0;
    case (op)
      CMD_ALLOC: begin
        // first fit: lowest clear mark below the managed count
        for (k = 0; k < span && !found; k++) begin
          if (!page_mark[k]) begin
            page_mark[k]  = 1'b1;
            used_total++;
            r.alloc_index = IDX_W'(k);
            found         = 1'b1;
          end
        end
        if (!found) r.status = STAT_OOM;
      end
      CMD_FREE, CMD_MARK: begin
        // A free of a free page or a mark of a used page changes nothing.
        if (idx >= span) begin
          r.status = STAT_RANGE;
        end else if (op == CMD_FREE) begin
          if (page_mark[idx]) begin
            page_mark[idx] = 1'b0;
            used_total--;
          end
        end else if (!page_mark[idx]) begin
          page_mark[idx] = 1'b1;
          used_total++;
        end
      end
      default: ;
    endcase
    r.used_pages = CNT_W'(used_total);
    r.free_pages = CNT_W'(span - used_total);
    return r;
  endfunction

  // Called right after a rising edge. Start stays high after a transaction;
  // the caller decides whether to drop it for a gap.
  task automatic send_page_cmd(cmd_e op, logic [IDX_W-1:0] idx);
    start_i      <= 1'b1;
    cmd_i        <= op;
    page_index_i <= idx;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_page_op(op, idx));
    cmds_sent++;
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Optional sender gap. Junk on the command fields while start is low.
  task automatic sender_gap(int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start_i      <= 1'b0;
      cmd_i        <= CMD_W'($urandom);
      page_index_i <= IDX_W'($urandom);
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 4)) @(posedge clk_i);
    end
  endtask

  // Register write with the block idle. The DUT clears its map, so the
  // bench copy does too.
  task automatic set_page_count(logic [CNT_W-1:0] value);
    start_i <= 1'b0;
    wait_results_drained();
    repeat (4) @(posedge clk_i);
    page_count_i    <= value;
    page_count_we_i <= 1'b1;
    @(posedge clk_i);
    page_count_we_i <= 1'b0;
    pages_cfg        = value;
    page_mark        = '0;
    used_total       = 0;
  endtask

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result checker: every done pulse pops the oldest pending result.
  always @(posedge clk_i) begin
    page_result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (status_o == STAT_OK && alloc_index_o != 0) grants_seen++;
      if (status_o == STAT_OOM) oom_seen++;
      if (status_o == STAT_RANGE) range_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: index %0d status %0d used %0d free %0d",
               alloc_index_o, status_o, used_pages_o, free_pages_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("alloc_index", CNT_W'(want.alloc_index), CNT_W'(alloc_index_o));
        check_field("status", CNT_W'(want.status), CNT_W'(status_o));
        check_field("used_pages", want.used_pages, used_pages_o);
        check_field("free_pages", want.free_pages, free_pages_o);
      end
    end
  end

  // Full 1024-page map after reset: grants, frees, no-op free/mark, top page.
  task automatic test_basic_ops();
    send_page_cmd(CMD_QUERY, '0);
    send_page_cmd(CMD_ALLOC, '0);
    send_page_cmd(CMD_ALLOC, '1);
    send_page_cmd(CMD_FREE, 10'd0);
    send_page_cmd(CMD_ALLOC, '0);          // hole at 0 refilled first
    send_page_cmd(CMD_FREE, 10'd5);        // already free: no change
    send_page_cmd(CMD_MARK, 10'd1);        // already used: no change
    send_page_cmd(CMD_MARK, 10'd1023);
    send_page_cmd(CMD_FREE, 10'd1023);
    send_page_cmd(CMD_QUERY, '1);
  endtask

  // Three-page map: fill, run out, bounce off the range limit, reuse a page.
  task automatic test_small_map();
    set_page_count(11'd3);
    repeat (3) send_page_cmd(CMD_ALLOC, '0);
    send_page_cmd(CMD_ALLOC, '0);          // out of memory
    send_page_cmd(CMD_FREE, 10'd3);        // just past the end
    send_page_cmd(CMD_MARK, 10'd1023);
    send_page_cmd(CMD_FREE, 10'd1);
    send_page_cmd(CMD_ALLOC, '0);
  endtask

  // Zero pages, a count past the map (saturates) and a single page.
  task automatic test_count_corners();
    set_page_count(11'd0);
    send_page_cmd(CMD_ALLOC, '0);
    send_page_cmd(CMD_FREE, 10'd0);
    send_page_cmd(CMD_MARK, 10'd0);
    set_page_count(11'h7FF);
    send_page_cmd(CMD_MARK, 10'd1023);
    send_page_cmd(CMD_ALLOC, '0);
    set_page_count(11'd1);
    send_page_cmd(CMD_ALLOC, '0);
    send_page_cmd(CMD_ALLOC, '0);
  endtask

  // One random phase at a given map size and sender idle rate. With
  // drain_pauses set, the sender sometimes holds off until nothing is pending.
  task automatic run_random_phase(logic [CNT_W-1:0] pages, int unsigned n_items,
                                  int unsigned idle_pct, bit drain_pauses);
    int unsigned      span;
    int unsigned      sel;
    cmd_e             op;
    logic [IDX_W-1:0] idx;
    set_page_count(pages);
    span = (pages > MAP_PAGES) ? MAP_PAGES : pages;
    repeat (n_items) begin
      sel = $urandom_range(99);
      if (sel < 40)      op = CMD_ALLOC;
      else if (sel < 70) op = CMD_FREE;
      else if (sel < 85) op = CMD_MARK;
      else               op = CMD_QUERY;
      // First fit packs pages low, so low indices mostly hit used pages.
      sel = $urandom_range(99);
      if (span == 0 || sel < 15)
        idx = IDX_W'($urandom);
      else if (sel < 60)
        idx = IDX_W'($urandom_range(((span < 64) ? span : 64) - 1));
      else
        idx = IDX_W'($urandom_range(span - 1));
      send_page_cmd(op, idx);
      if (drain_pauses && $urandom_range(19) == 0) begin
        start_i <= 1'b0;
        wait_results_drained();
      end else begin
        sender_gap(idle_pct);
      end
    end
  endtask

  task automatic test_random();
    run_random_phase(11'd16, 80, 0, 1'b0);
    run_random_phase(11'd1024, 80, 51, 1'b1);
    run_random_phase(11'd5, 80, 17, 1'b0);
    run_random_phase(11'h7FF, 80, 0, 1'b0);
    run_random_phase(CNT_W'($urandom_range(1, 1024)), 80, 51, 1'b1);
    run_random_phase(11'd1, 80, 17, 1'b1);
  endtask

  initial begin
    fail_count   = 0;
    cmds_sent    = 0;
    results_seen = 0;
    grants_seen  = 0;
    oom_seen     = 0;
    range_seen   = 0;
    page_mark    = '0;
    used_total   = 0;
    pages_cfg    = CNT_W'(PMA_PAGE_COUNT_RESET);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_small_map();
    test_count_corners();
    test_random();

    // Drain, bounded, then give any stray pulse time to appear.
    start_i <= 1'b0;
    repeat (4000) if (pending_results.size() != 0) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    repeat (40) @(posedge clk_i);

    $display("Run: %0d commands over map sizes 0, 1, 3, 5, 16, 1024 and oversize;",
             cmds_sent);
    $display("  %0d results checked (%0d nonzero grants, %0d out of memory, %0d out of range)",
             results_seen, grants_seen, oom_seen, range_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: a correct run ends far sooner.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/pma_pkg.sv
hw/rtl/page_map_allocator.sv
dv/tb_top.sv
